FILE: hdl/msnu_pkg.sv
// Shared types and constants for the masked sprite nearest upscaler.
`default_nettype none
package msnu_pkg;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int SCALE_W = 4;
  localparam int SIDE_W  = 7;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;

  // Register indexes (word address = paddr[4:2])
  localparam logic [2:0] REG_SCALE      = 3'd0;
  localparam logic [2:0] REG_WIDTH      = 3'd1;
  localparam logic [2:0] REG_HEIGHT     = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X   = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd4;
  localparam logic [2:0] REG_BACKGROUND = 3'd5;

  // Configuration as seen by the front part
  typedef struct packed {
    logic [SCALE_W-1:0]        scale;
    logic [SIDE_W-1:0]         sprite_width;
    logic [SIDE_W-1:0]         sprite_height;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [COLOR_W-1:0]        background_color;
  } cfg_t;

  // One block to draw: corner, color, side length and end-of-sprite flag
  typedef struct packed {
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [COLOR_W-1:0] color;
    logic [SCALE_W-1:0] scale;
    logic               last_pixel;
  } desc_t;

endpackage : msnu_pkg
`default_nettype wire

FILE: hdl/masked_sprite_nearest_upscaler_core.sv
// Top level of the masked sprite nearest upscaler: config registers and part wiring.
//
// Usage: source pixels enter in raster order on the input channel
// (in_valid_i/in_ready_o with pixel_color_i and opaque_i). Each pixel turns
// into a scale-by-scale block of screen writes on the output channel
// (out_valid_o/out_ready_i), emitted row by row, left to right. block_last_o
// marks the final write of a block, sprite_last_o the final write of the
// sprite. An accepted pixel is queued as a descriptor, and its first write then
// passes the output register. Throughput: one write per cycle while the receiver
// is ready, set by the back part's single write path; an item gives scale*scale
// writes (16 at scale 4, one at scale 1). The front part takes a new item each
// cycle while the descriptor queue has room, so it keeps accepting while the back
// part works or the receiver stalls; a stall holds the output register and then
// fills the queue, after which in_ready_o drops. A scale of zero drops the pixel's
// writes but still advances the position counters. Reset clears the counters,
// the queue and the output valid, and loads the register defaults (scale 1,
// 32x32 sprite, origin 0, black background). Write registers over the APB
// port only while the block is idle.
`default_nettype none
module masked_sprite_nearest_upscaler_core
  import msnu_pkg::*;
#(
  parameter int MAX_SPRITE_SIDE = 64,
  parameter int MAX_SCALE       = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // source pixels
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [COLOR_W-1:0]   pixel_color_i,
  input  wire logic                 opaque_i,
  // screen writes
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [COORD_W-1:0] screen_x_o,
  output logic signed [COORD_W-1:0] screen_y_o,
  output logic [COLOR_W-1:0]        color_o,
  output logic                      block_last_o,
  output logic                      sprite_last_o
);

  localparam int QueueDepth = 4;

  cfg_t        cfg_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  logic        push, full, pop, empty;
  desc_t       push_data, head;

  // Register file: word-addressed, write on the APB access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale            <= SCALE_W'(1);
      cfg_q.sprite_width     <= SIDE_W'(32);
      cfg_q.sprite_height    <= SIDE_W'(32);
      cfg_q.origin_x         <= '0;
      cfg_q.origin_y         <= '0;
      cfg_q.background_color <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCALE:      cfg_q.scale            <= pwdata[SCALE_W-1:0];
        REG_WIDTH:      cfg_q.sprite_width     <= pwdata[SIDE_W-1:0];
        REG_HEIGHT:     cfg_q.sprite_height    <= pwdata[SIDE_W-1:0];
        REG_ORIGIN_X:   cfg_q.origin_x         <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:   cfg_q.origin_y         <= pwdata[COORD_W-1:0];
        REG_BACKGROUND: cfg_q.background_color <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register values
  always_comb begin
    case (reg_idx)
      REG_SCALE:      prdata = DATA_W'(cfg_q.scale);
      REG_WIDTH:      prdata = DATA_W'(cfg_q.sprite_width);
      REG_HEIGHT:     prdata = DATA_W'(cfg_q.sprite_height);
      REG_ORIGIN_X:   prdata = DATA_W'(unsigned'(cfg_q.origin_x));
      REG_ORIGIN_Y:   prdata = DATA_W'(unsigned'(cfg_q.origin_y));
      REG_BACKGROUND: prdata = DATA_W'(cfg_q.background_color);
      default:        prdata = '0;
    endcase
  end

  // Front: position tracking and block descriptors
  msnu_front #(
    .MAX_SPRITE_SIDE(MAX_SPRITE_SIDE),
    .MAX_SCALE      (MAX_SCALE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_color_i(pixel_color_i),
    .opaque_i     (opaque_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  // Queue decouples pixel intake from block expansion
  msnu_fifo #(
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  // Back: one screen write per cycle into the output register while not stalled
  msnu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .color_o      (color_o),
    .block_last_o (block_last_o),
    .sprite_last_o(sprite_last_o)
  );

endmodule : masked_sprite_nearest_upscaler_core
`default_nettype wire

FILE: hdl/msnu_fifo.sv
// Small descriptor queue between the front and back parts.
`default_nettype none
module msnu_fifo
  import msnu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire desc_t push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output desc_t      head_o,
  output logic       empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  desc_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule : msnu_fifo
`default_nettype wire

FILE: hdl/msnu_front.sv
// Front part: accept source pixels, track position, build block descriptors.
`default_nettype none
module msnu_front
  import msnu_pkg::*;
#(
  parameter int MAX_SPRITE_SIDE = 64,
  parameter int MAX_SCALE       = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [COLOR_W-1:0] pixel_color_i,
  input  wire logic               opaque_i,
  output logic                    push_o,
  output desc_t                   push_data_o,
  input  wire logic               full_i
);

  localparam int CntW  = $clog2(MAX_SPRITE_SIDE);
  localparam int SideW = $clog2(MAX_SPRITE_SIDE + 1);
  localparam int CmpW  = (SideW > SIDE_W) ? SideW : SIDE_W;

  logic [CntW-1:0]    col_q, col_d, row_q, row_d;
  logic [CmpW-1:0]    w_raw, h_raw, w_c, h_c;
  logic [CmpW-1:0]    col_eff, row_eff, col_inc, row_inc;
  logic [SCALE_W-1:0] s_sat;
  logic               accept;

  // Clamp sizes and scale into their legal ranges
  always_comb begin
    w_raw = CmpW'(cfg_i.sprite_width);
    h_raw = CmpW'(cfg_i.sprite_height);
    if (w_raw == '0) begin
      w_c = CmpW'(1);
    end else if (w_raw > CmpW'(MAX_SPRITE_SIDE)) begin
      w_c = CmpW'(MAX_SPRITE_SIDE);
    end else begin
      w_c = w_raw;
    end
    if (h_raw == '0) begin
      h_c = CmpW'(1);
    end else if (h_raw > CmpW'(MAX_SPRITE_SIDE)) begin
      h_c = CmpW'(MAX_SPRITE_SIDE);
    end else begin
      h_c = h_raw;
    end
    s_sat = (int'(cfg_i.scale) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : cfg_i.scale;
  end

  // Restart a counter that sits beyond a lowered size, then step
  always_comb begin
    col_eff = (CmpW'(col_q) >= w_c) ? '0 : CmpW'(col_q);
    row_eff = (CmpW'(row_q) >= h_c) ? '0 : CmpW'(row_q);
    col_inc = col_eff + 1'b1;
    row_inc = row_eff + 1'b1;
    if (col_inc >= w_c) begin
      col_d = '0;
      row_d = (row_inc >= h_c) ? '0 : CntW'(row_inc);
    end else begin
      col_d = CntW'(col_inc);
      row_d = CntW'(row_eff);
    end
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  // Drop the pixel's writes when scale is zero; the counters still advance
  assign push_o     = accept && (s_sat != '0);

  always_comb begin
    push_data_o.base_x     = cfg_i.origin_x + (COORD_W'(col_eff) * COORD_W'(s_sat));
    push_data_o.base_y     = cfg_i.origin_y + (COORD_W'(row_eff) * COORD_W'(s_sat));
    push_data_o.color      = opaque_i ? pixel_color_i : cfg_i.background_color;
    push_data_o.scale      = s_sat;
    push_data_o.last_pixel = (col_eff == w_c - 1'b1) && (row_eff == h_c - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule : msnu_front
`default_nettype wire

FILE: hdl/msnu_back.sv
// Back part: walk each block row by row; one write per cycle unless stalled.
`default_nettype none
module msnu_back
  import msnu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire desc_t               head_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [COORD_W-1:0] screen_x_o,
  output logic signed [COORD_W-1:0] screen_y_o,
  output logic [COLOR_W-1:0]       color_o,
  output logic                     block_last_o,
  output logic                     sprite_last_o
);

  logic [SCALE_W-1:0] dx_q, dy_q;
  logic               out_valid_q;
  logic               fire, dx_last, dy_last, blk_last;

  assign fire     = !empty_i && (!out_valid_q || out_ready_i);
  assign dx_last  = (dx_q == head_i.scale - 1'b1);
  assign dy_last  = (dy_q == head_i.scale - 1'b1);
  assign blk_last = dx_last && dy_last;
  assign pop_o    = fire && blk_last;
  assign out_valid_o = out_valid_q;

  // Output register: payload holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (fire) begin
      screen_x_o    <= head_i.base_x + COORD_W'(dx_q);
      screen_y_o    <= head_i.base_y + COORD_W'(dy_q);
      color_o       <= head_i.color;
      block_last_o  <= blk_last;
      sprite_last_o <= blk_last && head_i.last_pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dx_q        <= '0;
      dy_q        <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        if (dx_last) begin
          dx_q <= '0;
          dy_q <= dy_last ? '0 : dy_q + 1'b1;
        end else begin
          dx_q <= dx_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule : msnu_back
`default_nettype wire
